FILE: rtl/core/ahms_pkg.sv
package ahms_pkg;

    localparam int unsigned MAX_READ_LEN = 65536;
    localparam int POS_W = $clog2(MAX_READ_LEN + 1);

    localparam int BASE_W = 8;
    localparam int CNT_W  = 16;
    localparam int POS_OUT_W = 16;
    localparam int FRAC_W = 16;
    localparam int CONF_W = FRAC_W + 1;
    localparam int DIV_STEP_W = $clog2(CONF_W + 1);

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_READ_LEN);
    localparam logic [POS_W-1:0] POS_FIRST_EVT = POS_W'(2);

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] MIN_EVENTS_RST = CNT_W'(3);

    localparam logic [BASE_W-1:0] CH_A = 8'h41;
    localparam logic [BASE_W-1:0] CH_C = 8'h43;
    localparam logic [BASE_W-1:0] CH_G = 8'h47;
    localparam logic [BASE_W-1:0] CH_T = 8'h54;
    localparam logic [BASE_W-1:0] CH_U = 8'h55;
    localparam logic [BASE_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [BASE_W-1:0] CH_LOW_Z = 8'h7A;
    localparam logic [BASE_W-1:0] CASE_DELTA = 8'h20;

    localparam logic KIND_EVENT   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_SUM
    } t_state;

    typedef struct packed {
        logic                 hit;
        logic                 over;
        logic [POS_OUT_W-1:0] pos;
        logic [CNT_W-1:0]     events;
        logic [CNT_W-1:0]     hotspots;
    } t_scan_info;

    function automatic logic [BASE_W-1:0] fold_case(input logic [BASE_W-1:0] c);
        if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            return c - CASE_DELTA;
        end
        return c;
    endfunction

    function automatic logic is_weak(input logic [BASE_W-1:0] c);
        return (c == CH_A) || (c == CH_T) || (c == CH_U);
    endfunction

    function automatic logic is_purine(input logic [BASE_W-1:0] c);
        return (c == CH_A) || (c == CH_G);
    endfunction

endpackage

FILE: rtl/core/aid_hotspot_mutation_scan.sv
// Streams one aligned base pair per request. A C-to-T/U event at position 2 or
// later gives an event result (kind 0) with its position; the request flagged
// final_base also gives a summary (kind 1), after any event of that base, and
// the read state is then cleared. Non-final bases are taken one per cycle while
// the result side keeps up. After the final base the input is held off through the
// evaluate and summary-load states on a negative call, and on a positive call
// also while the restoring subtract/compare divider forms the 17-bit Q1.16
// confidence; a stalled result side holds it off longer. The user must write
// min_events through i_cfg_wr_en/i_cfg_wr_data only while the block is idle;
// the block itself does not enforce it.
module aid_hotspot_mutation_scan
    import ahms_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CNT_W-1:0]     i_cfg_wr_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [BASE_W-1:0]    i_anchor_base,
    input  logic [BASE_W-1:0]    i_read_base,
    input  logic                 i_is_switch_anchor,
    input  logic                 i_lengths_match,
    input  logic                 i_final_base,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_kind,
    output logic [POS_OUT_W-1:0] o_position,
    output logic                 o_detected,
    output logic [CNT_W-1:0]     o_event_count,
    output logic [CNT_W-1:0]     o_hotspot_count,
    output logic [CONF_W-1:0]    o_confidence,
    output logic                 o_length_error,
    output logic                 o_end_of_run
);

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0] r_min_events;
    logic             r_gate;
    logic             r_over;
    logic             r_det;

    logic                 r_out_valid;
    logic                 r_kind;
    logic [POS_OUT_W-1:0] r_position;
    logic                 r_detected;
    logic [CNT_W-1:0]     r_event_count;
    logic [CNT_W-1:0]     r_hotspot_count;
    logic [CONF_W-1:0]    r_confidence;
    logic                 r_length_error;
    logic                 r_end_of_run;

    t_scan_info        w_info;
    logic              w_gate;
    logic              w_out_free;
    logic              w_ready;
    logic              w_take;
    logic              w_load_evt;
    logic              w_load_sum;
    logic              w_div_start;
    logic              w_det;
    logic              w_div_busy;
    logic [CONF_W-1:0] w_quotient;

    assign w_gate     = i_is_switch_anchor && i_lengths_match;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_take     = i_valid && w_ready;
    assign w_load_evt = w_take && w_info.hit;

    assign w_det = r_gate && (w_info.events != '0) && (w_info.events >= r_min_events) &&
                   ({w_info.hotspots, 1'b0} >= {1'b0, w_info.events});

    ahms_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (w_take),
        .i_clear       (w_load_sum),
        .i_gate        (w_gate),
        .i_anchor_base (i_anchor_base),
        .i_read_base   (i_read_base),
        .o_info        (w_info)
    );

    ahms_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_info.hotspots),
        .i_divisor  (w_info.events),
        .o_busy     (w_div_busy),
        .o_quotient (w_quotient)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_take && i_final_base) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = w_det ? ST_DIV : ST_SUM;
            end
            ST_DIV: begin
                if (!w_div_busy) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ready     = 1'b0;
        w_div_start = 1'b0;
        w_load_sum  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_ready = w_out_free;
            end
            ST_EVAL: begin
                w_div_start = w_det;
            end
            ST_DIV: begin
            end
            ST_SUM: begin
                w_load_sum = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_min_events <= MIN_EVENTS_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_min_events <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_final_base) begin
            r_gate <= w_gate;
            r_over <= w_info.over;
        end
        if (r_state == ST_EVAL) begin
            r_det <= w_det;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_evt || w_load_sum) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_evt) begin
            r_kind          <= KIND_EVENT;
            r_position      <= w_info.pos;
            r_detected      <= 1'b0;
            r_event_count   <= '0;
            r_hotspot_count <= '0;
            r_confidence    <= '0;
            r_length_error  <= 1'b0;
            r_end_of_run    <= !i_final_base;
        end else if (w_load_sum) begin
            r_kind          <= KIND_SUMMARY;
            r_position      <= '0;
            r_detected      <= r_det;
            r_event_count   <= r_gate ? w_info.events : '0;
            r_hotspot_count <= r_gate ? w_info.hotspots : '0;
            r_confidence    <= r_det ? w_quotient : '0;
            r_length_error  <= r_gate && r_over;
            r_end_of_run    <= 1'b1;
        end
    end

    assign o_ready         = w_ready;
    assign o_valid         = r_out_valid;
    assign o_kind          = r_kind;
    assign o_position      = r_position;
    assign o_detected      = r_detected;
    assign o_event_count   = r_event_count;
    assign o_hotspot_count = r_hotspot_count;
    assign o_confidence    = r_confidence;
    assign o_length_error  = r_length_error;
    assign o_end_of_run    = r_end_of_run;

    a_det_conf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_kind == KIND_SUMMARY) && r_detected |->
            (r_event_count != '0) && (r_confidence >= CONF_W'(1 << (FRAC_W - 1))) &&
            (r_confidence <= CONF_W'(1 << FRAC_W)))
        else $error("positive call with bad confidence");

    a_evt_before_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_kind == KIND_EVENT) && !r_end_of_run |-> r_state != ST_IDLE)
        else $error("summary missing after final event");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> !w_ready)
        else $error("request taken during divide");

endmodule

FILE: rtl/core/ahms_scan.sv
module ahms_scan
    import ahms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic              i_clear,
    input  logic              i_gate,
    input  logic [BASE_W-1:0] i_anchor_base,
    input  logic [BASE_W-1:0] i_read_base,
    output t_scan_info        o_info
);

    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic [BASE_W-1:0] r_prev0;
    logic [BASE_W-1:0] r_prev1;
    logic [CNT_W-1:0]  r_events;
    logic [CNT_W-1:0]  n_events;
    logic [CNT_W-1:0]  r_hots;
    logic [CNT_W-1:0]  n_hots;
    logic [BASE_W-1:0] w_a;
    logic [BASE_W-1:0] w_b;
    logic              w_hit;
    logic              w_hot;

    assign w_a = fold_case(i_anchor_base);
    assign w_b = fold_case(i_read_base);

    assign w_hit = i_gate && (r_pos >= POS_FIRST_EVT) && (r_pos < POS_MAX) &&
                   (w_a == CH_C) && ((w_b == CH_T) || (w_b == CH_U)) &&
                   (r_events != CNT_MAX);
    assign w_hot = is_weak(r_prev1) && is_purine(r_prev0);

    always_comb begin
        n_pos    = (r_pos != POS_MAX) ? r_pos + POS_W'(1) : r_pos;
        n_events = w_hit ? r_events + CNT_W'(1) : r_events;
        n_hots   = (w_hit && w_hot) ? r_hots + CNT_W'(1) : r_hots;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_pos    <= '0;
            r_prev0  <= '0;
            r_prev1  <= '0;
            r_events <= '0;
            r_hots   <= '0;
        end else if (i_take) begin
            r_pos    <= n_pos;
            r_prev0  <= w_a;
            r_prev1  <= r_prev0;
            r_events <= n_events;
            r_hots   <= n_hots;
        end
    end

    assign o_info.hit      = w_hit;
    assign o_info.over     = (r_pos >= POS_MAX);
    assign o_info.pos      = POS_OUT_W'(r_pos);
    assign o_info.events   = r_events;
    assign o_info.hotspots = r_hots;

    a_hot_le_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hots <= r_events)
        else $error("hotspot count exceeds event count");

endmodule

FILE: rtl/core/ahms_div.sv
module ahms_div
    import ahms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CNT_W-1:0]  i_dividend,
    input  logic [CNT_W-1:0]  i_divisor,
    output logic              o_busy,
    output logic [CONF_W-1:0] o_quotient
);

    logic                  r_busy;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic [CNT_W:0]        r_rem;
    logic [CONF_W-1:0]     r_quo;
    logic [CNT_W-1:0]      r_div;
    logic                  w_ge;
    logic [CNT_W:0]        w_diff;
    logic [CNT_W-1:0]      w_left;

    // restoring divide of {dividend, FRAC_W zeros}; dividend <= divisor
    assign w_ge   = (r_rem >= {1'b0, r_div});
    assign w_diff = r_rem - {1'b0, r_div};
    assign w_left = w_ge ? w_diff[CNT_W-1:0] : r_rem[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_STEP_W'(CONF_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - DIV_STEP_W'(1);
            r_busy <= (r_cnt != DIV_STEP_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend};
            r_div <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= {w_left, 1'b0};
            r_quo <= {r_quo[CONF_W-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> ##(CONF_W-1) r_busy ##1 !r_busy)
        else $error("divide length wrong");

endmodule
